### rtl/core/lcbb_pkg.sv
// Shared types and codes for the LRU cache with byte budget.
// Used by the controller, the datapath, the top level and the checker.
package lcbb_pkg;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_LOOKUP = 3'd1;
	localparam logic [2:0] CMD_TOUCH  = 3'd2;
	localparam logic [2:0] CMD_ERASE  = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] KIND_EVICT  = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;
	localparam logic [0:0] REG_MAX_BYTES   = 1'b1;

	localparam logic [5:0]  MAX_ENTRIES_RST = 6'd32;
	localparam logic [31:0] MAX_BYTES_RST   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [15:0]        key_robot;
		logic signed [31:0] key_frame;
		logic [31:0]        scan_bytes;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        out_robot;
		logic signed [31:0] out_frame;
		logic               found;
		logic [5:0]         entry_count;
		logic [31:0]        total_bytes;
		logic [31:0]        rejected_total;
		logic [31:0]        evicted_total;
		logic               last;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_FIND,
		OP_DROP,
		OP_EVICT,
		OP_TOUCH,
		OP_PLACE,
		OP_CLEAR,
		OP_REJECT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       emit;
		logic [1:0] emit_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       hit;
		logic       key_ok;
		logic       cfg_ok;
		logic       oversize;
		logic       need_evict;
		logic       out_free;
	} dp_sts_t;

endpackage

### rtl/core/lcbb_ctrl.sv
// Command sequencer for the LRU cache with byte budget.
// Drives datapath operations from lcbb_pkg command and status structs.
module lcbb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  lcbb_pkg::dp_sts_t sts,
	output lcbb_pkg::dp_cmd_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_DECIDE,
		S_SIZE,
		S_LOOP,
		S_REJ,
		S_STAT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d       = state_q;
		ctl.op        = lcbb_pkg::OP_NONE;
		ctl.emit      = 1'b0;
		ctl.emit_kind = lcbb_pkg::KIND_STATUS;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.op  = lcbb_pkg::OP_LATCH;
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				ctl.op  = lcbb_pkg::OP_FIND;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_STAT;
				case (sts.cmd)
					lcbb_pkg::CMD_INSERT: begin
						if (!sts.cfg_ok || !sts.key_ok) begin
							state_d = S_REJ;
						end else begin
							if (sts.hit) begin
								ctl.op = lcbb_pkg::OP_DROP;
							end
							state_d = S_SIZE;
						end
					end
					lcbb_pkg::CMD_TOUCH: begin
						if (sts.hit) begin
							ctl.op = lcbb_pkg::OP_TOUCH;
						end
					end
					lcbb_pkg::CMD_ERASE: begin
						if (sts.hit) begin
							ctl.op = lcbb_pkg::OP_DROP;
						end
					end
					lcbb_pkg::CMD_CLEAR: begin
						ctl.op = lcbb_pkg::OP_CLEAR;
					end
					default: begin
						state_d = S_STAT;
					end
				endcase
			end
			S_SIZE: begin
				state_d = sts.oversize ? S_REJ : S_LOOP;
			end
			S_LOOP: begin
				if (sts.need_evict) begin
					if (sts.out_free) begin
						ctl.op        = lcbb_pkg::OP_EVICT;
						ctl.emit      = 1'b1;
						ctl.emit_kind = lcbb_pkg::KIND_EVICT;
					end
				end else begin
					ctl.op  = lcbb_pkg::OP_PLACE;
					state_d = S_STAT;
				end
			end
			S_REJ: begin
				if (sts.out_free) begin
					ctl.op        = lcbb_pkg::OP_REJECT;
					ctl.emit      = 1'b1;
					ctl.emit_kind = lcbb_pkg::KIND_REJECT;
					state_d       = S_STAT;
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = lcbb_pkg::KIND_STATUS;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/lcbb_datapath.sv
// Slot store, age ranks, totals, limits and result register of the cache.
// Executes one lcbb_pkg operation per cycle under control of lcbb_ctrl.
module lcbb_datapath #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lcbb_pkg::req_t    req,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  lcbb_pkg::dp_cmd_t ctl,
	output lcbb_pkg::dp_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lcbb_pkg::rsp_t    rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DEPTH-1:0] valid_q;
	logic [15:0]      robot_q [DEPTH];
	logic [31:0]      frame_q [DEPTH];
	logic [31:0]      size_q  [DEPTH];
	logic [IW-1:0]    rank_q  [DEPTH];
	logic [CW-1:0]    count_q;
	logic [32:0]      bytes_q;
	logic [31:0]      rej_q;
	logic [31:0]      evc_q;
	logic [5:0]       max_entries_q;
	logic [31:0]      max_bytes_q;
	lcbb_pkg::req_t   item_q;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic             rsp_valid_q;
	lcbb_pkg::rsp_t   rsp_q;
	lcbb_pkg::rsp_t   rsp_d;

	logic             hit_c;
	logic [IW-1:0]    hit_idx_c;
	logic [IW-1:0]    old_idx;
	logic             free_any;
	logic [IW-1:0]    free_idx;
	logic [IW-1:0]    drop_idx;
	logic [IW-1:0]    drop_rank;
	logic [5:0]       limit;
	logic             drop_en;

	always_comb begin
		hit_c     = 1'b0;
		hit_idx_c = '0;
		old_idx   = '0;
		free_any  = 1'b0;
		free_idx  = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (valid_q[i] && robot_q[i] == item_q.key_robot
					&& frame_q[i] == item_q.key_frame) begin
				hit_c     = 1'b1;
				hit_idx_c = IW'(i);
			end
			if (valid_q[i] && rank_q[i] == '0) begin
				old_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign limit     = (max_entries_q < 6'(DEPTH)) ? max_entries_q : 6'(DEPTH);
	assign drop_idx  = (ctl.op == lcbb_pkg::OP_EVICT) ? old_idx : hit_idx_q;
	assign drop_rank = rank_q[drop_idx];
	assign drop_en   = (ctl.op == lcbb_pkg::OP_DROP) || (ctl.op == lcbb_pkg::OP_EVICT);

	assign sts.cmd        = item_q.cmd;
	assign sts.hit        = hit_q;
	assign sts.key_ok     = (item_q.key_robot != 16'd0) && !item_q.key_frame[31];
	assign sts.cfg_ok     = (max_entries_q != 6'd0) && (max_bytes_q != 32'd0);
	assign sts.oversize   = item_q.scan_bytes > max_bytes_q;
	assign sts.need_evict = (count_q != '0)
		&& ((7'(count_q) + 7'd1 > 7'(limit))
		|| (34'(bytes_q) + 34'(item_q.scan_bytes) > 34'(max_bytes_q)));
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (ctl.op == lcbb_pkg::OP_LATCH) begin
			item_q <= req;
		end
		if (ctl.op == lcbb_pkg::OP_FIND) begin
			hit_idx_q <= hit_idx_c;
		end
		if (ctl.op == lcbb_pkg::OP_PLACE && free_any) begin
			robot_q[free_idx] <= item_q.key_robot;
			frame_q[free_idx] <= item_q.key_frame;
			size_q[free_idx]  <= item_q.scan_bytes;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (ctl.op == lcbb_pkg::OP_TOUCH && IW'(i) == hit_idx_q) begin
				rank_q[i] <= IW'(count_q - CW'(1));
			end else if (ctl.op == lcbb_pkg::OP_PLACE && free_any
					&& IW'(i) == free_idx) begin
				rank_q[i] <= IW'(count_q);
			end else if ((drop_en || ctl.op == lcbb_pkg::OP_TOUCH) && valid_q[i]
					&& rank_q[i] > drop_rank) begin
				rank_q[i] <= rank_q[i] - IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			count_q       <= '0;
			bytes_q       <= '0;
			rej_q         <= '0;
			evc_q         <= '0;
			hit_q         <= 1'b0;
			max_entries_q <= lcbb_pkg::MAX_ENTRIES_RST;
			max_bytes_q   <= lcbb_pkg::MAX_BYTES_RST;
		end else begin
			if (cfg_we && cfg_index == 2'(lcbb_pkg::REG_MAX_ENTRIES)) begin
				max_entries_q <= cfg_data[5:0];
			end
			if (cfg_we && cfg_index == 2'(lcbb_pkg::REG_MAX_BYTES)) begin
				max_bytes_q <= cfg_data;
			end
			case (ctl.op)
				lcbb_pkg::OP_FIND: begin
					hit_q <= hit_c;
				end
				lcbb_pkg::OP_DROP, lcbb_pkg::OP_EVICT: begin
					valid_q[drop_idx] <= 1'b0;
					count_q           <= count_q - CW'(1);
					bytes_q           <= bytes_q - 33'(size_q[drop_idx]);
					if (ctl.op == lcbb_pkg::OP_EVICT) begin
						evc_q <= evc_q + 32'd1;
					end
				end
				lcbb_pkg::OP_PLACE: begin
					if (free_any) begin
						valid_q[free_idx] <= 1'b1;
						count_q           <= count_q + CW'(1);
						bytes_q           <= bytes_q + 33'(item_q.scan_bytes);
					end
				end
				lcbb_pkg::OP_CLEAR: begin
					valid_q <= '0;
					count_q <= '0;
					bytes_q <= '0;
				end
				lcbb_pkg::OP_REJECT: begin
					rej_q <= rej_q + 32'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		rsp_d      = '0;
		rsp_d.kind = ctl.emit_kind;
		case (ctl.emit_kind)
			lcbb_pkg::KIND_EVICT: begin
				rsp_d.out_robot = robot_q[old_idx];
				rsp_d.out_frame = frame_q[old_idx];
			end
			lcbb_pkg::KIND_REJECT: begin
				rsp_d.out_robot = item_q.key_robot;
				rsp_d.out_frame = item_q.key_frame;
			end
			default: begin
				rsp_d.found = hit_q && (item_q.cmd == lcbb_pkg::CMD_LOOKUP
					|| item_q.cmd == lcbb_pkg::CMD_TOUCH
					|| item_q.cmd == lcbb_pkg::CMD_ERASE);
				rsp_d.entry_count    = 6'(count_q);
				rsp_d.total_bytes    = bytes_q[31:0];
				rsp_d.rejected_total = rej_q;
				rsp_d.evicted_total  = evc_q;
				rsp_d.last           = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/lru_cache_byte_budget_unit.sv
// Top level of the LRU cache of scan sizes under an entry limit and a byte budget.
// Instantiates lcbb_ctrl and lcbb_datapath; types come from lcbb_pkg.
//
// One command is taken at a time. For lookup, touch, erase, clear and unknown
// commands the sequencer steps through its find, decide and status states, and
// the next command is accepted once it is back in idle. An insert rejected for
// its key or the configuration presents its reject item, then its status; an
// oversize insert passes the size check, its reject item and its status; a placed
// insert passes the size check, the eviction loop and its status. The eviction
// loop removes the oldest slot once per cycle while the result side is free. A
// stall on the result side holds the sequencer wherever it has an item to deliver.
module lru_cache_byte_budget_unit #(
	parameter int DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lcbb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lcbb_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);

	lcbb_pkg::dp_cmd_t ctl;
	lcbb_pkg::dp_sts_t sts;

	lcbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	lcbb_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### rtl/core/lcbb_checker.sv
// Port-level checks for lru_cache_byte_budget_unit, attached by bind.
// Uses the item types and codes from lcbb_pkg.
module lcbb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input lcbb_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result item changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Request taken again before the status item.");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind == lcbb_pkg::KIND_STATUS)))
		else $error("Last flag does not match the status kind.");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == lcbb_pkg::KIND_STATUS
		|-> rsp.out_robot == 16'd0 && rsp.out_frame == 32'sd0)
		else $error("Status item carries a key.");

	a_key_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != lcbb_pkg::KIND_STATUS
		|-> !rsp.found && rsp.entry_count == 6'd0 && rsp.total_bytes == 32'd0)
		else $error("Key item carries status fields.");

endmodule

bind lru_cache_byte_budget_unit lcbb_checker u_lcbb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/sv/lru_cache_byte_budget_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_cache_byte_budget_unit: directed and random commands,
// checked item by item against a behavioral LRU cache model. Depends on lcbb_pkg and the RTL.
module lru_cache_byte_budget_unit_tb;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 1500000;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	lcbb_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	lcbb_pkg::rsp_t rsp;
	logic           cfg_we;
	logic [1:0]     cfg_index;
	logic [31:0]    cfg_data;

	lru_cache_byte_budget_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Model state of the cache; the list is ordered oldest first.
	logic [5:0]  lim_entries;
	logic [31:0] lim_bytes;
	logic [15:0] held_robot[$];
	logic [31:0] held_frame[$];
	logic [31:0] held_size[$];
	logic [32:0] sum_bytes;
	logic [31:0] rejects;
	logic [31:0] evicts;

	lcbb_pkg::rsp_t pending_rsp[$];
	int   mismatches;
	int   cycles;
	int   burst_left;
	int   gap_left;
	int   stall_mode;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int find_key(logic [15:0] robot, logic [31:0] frame);
		for (int i = 0; i < held_robot.size(); i++)
			if (held_robot[i] == robot && held_frame[i] == frame)
				return i;
		return -1;
	endfunction

	function automatic void remove_at(int i);
		sum_bytes = sum_bytes - 33'(held_size[i]);
		held_robot.delete(i);
		held_frame.delete(i);
		held_size.delete(i);
	endfunction

	function automatic void add_held(logic [15:0] robot, logic [31:0] frame,
		logic [31:0] size);
		held_robot.insert(held_robot.size(), robot);
		held_frame.insert(held_frame.size(), frame);
		held_size.insert(held_size.size(), size);
	endfunction

	function automatic void expect_item(lcbb_pkg::rsp_t r);
		pending_rsp.insert(pending_rsp.size(), r);
	endfunction

	function automatic void push_key(logic [1:0] kind, logic [15:0] robot, logic [31:0] frame);
		lcbb_pkg::rsp_t r;
		r = '0;
		r.kind = kind;
		r.out_robot = robot;
		r.out_frame = frame;
		expect_item(r);
	endfunction

	function automatic void predict_cache(lcbb_pkg::req_t c);
		lcbb_pkg::rsp_t st;
		logic found;
		int s;
		int lim;
		logic [15:0] rb;
		logic [31:0] fr;
		logic [31:0] sz;
		found = 1'b0;
		case (c.cmd)
			lcbb_pkg::CMD_INSERT: begin
				if (lim_entries == 0 || lim_bytes == 0 || c.key_robot == 0
						|| c.key_frame[31]) begin
					rejects++;
					push_key(lcbb_pkg::KIND_REJECT, c.key_robot, c.key_frame);
				end else begin
					lim = (lim_entries < DEPTH) ? int'(lim_entries) : DEPTH;
					s = find_key(c.key_robot, c.key_frame);
					if (s >= 0)
						remove_at(s);
					if (c.scan_bytes > lim_bytes) begin
						rejects++;
						push_key(lcbb_pkg::KIND_REJECT, c.key_robot, c.key_frame);
					end else begin
						while (held_robot.size() > 0 && (held_robot.size() + 1 > lim
							|| sum_bytes + 33'(c.scan_bytes) > {1'b0, lim_bytes})) begin
							rb = held_robot[0];
							fr = held_frame[0];
							push_key(lcbb_pkg::KIND_EVICT, rb, fr);
							remove_at(0);
							evicts++;
						end
						add_held(c.key_robot, c.key_frame, c.scan_bytes);
						sum_bytes = sum_bytes + 33'(c.scan_bytes);
					end
				end
			end
			lcbb_pkg::CMD_LOOKUP: found = find_key(c.key_robot, c.key_frame) >= 0;
			lcbb_pkg::CMD_TOUCH: begin
				s = find_key(c.key_robot, c.key_frame);
				if (s >= 0) begin
					found = 1'b1;
					rb = held_robot[s];
					fr = held_frame[s];
					sz = held_size[s];
					held_robot.delete(s);
					held_frame.delete(s);
					held_size.delete(s);
					add_held(rb, fr, sz);
				end
			end
			lcbb_pkg::CMD_ERASE: begin
				s = find_key(c.key_robot, c.key_frame);
				if (s >= 0) begin
					found = 1'b1;
					remove_at(s);
				end
			end
			lcbb_pkg::CMD_CLEAR: begin
				held_robot.delete();
				held_frame.delete();
				held_size.delete();
				sum_bytes = '0;
			end
			default: ;
		endcase
		st = '0;
		st.kind = lcbb_pkg::KIND_STATUS;
		st.found = found;
		st.entry_count = 6'(held_robot.size());
		st.total_bytes = sum_bytes[31:0];
		st.rejected_total = rejects;
		st.evicted_total = evicts;
		st.last = 1'b1;
		expect_item(st);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			stall_mode <= stall_mode + 1;
			case ((stall_mode / 64) % 3)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				default: rsp_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		lcbb_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected item %p", rsp);
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p got %p", want, rsp);
				end
			end
		end
	end

	task automatic send_cmd(logic [2:0] cmd, logic [15:0] robot, logic [31:0] frame,
		logic [31:0] scan);
		lcbb_pkg::req_t c;
		if (burst_left == 0) begin
			gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 12);
			if (gap_left > 0) begin
				req_valid <= 1'b0;
				repeat (gap_left) @(posedge clk);
			end
		end
		burst_left--;
		c.cmd = cmd;
		c.key_robot = robot;
		c.key_frame = frame;
		c.scan_bytes = scan;
		req <= c;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_cache(c);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == 2'(lcbb_pkg::REG_MAX_ENTRIES))
			lim_entries = val[5:0];
		else if (idx == 2'(lcbb_pkg::REG_MAX_BYTES))
			lim_bytes = val;
	endtask

	task automatic test_directed();
		send_cmd(lcbb_pkg::CMD_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(lcbb_pkg::CMD_LOOKUP, 16'hFFFF, 32'h7FFF_FFFF, 32'h0);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd1, 32'd0, 32'd0);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd0, 32'd5, 32'd10);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd3, 32'h8000_0000, 32'd10);
		send_cmd(lcbb_pkg::CMD_TOUCH, 16'hFFFF, 32'h7FFF_FFFF, 32'h0);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd2, 32'd7, 32'd1);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd2, 32'd7, 32'd5);
		send_cmd(lcbb_pkg::CMD_ERASE, 16'd1, 32'd0, 32'h0);
		send_cmd(lcbb_pkg::CMD_ERASE, 16'd1, 32'd0, 32'h0);
		send_cmd(lcbb_pkg::CMD_LOOKUP, 16'd0, 32'hFFFF_FFFF, 32'h0);
		send_cmd(3'd5, 16'd2, 32'd7, 32'h0);
		send_cmd(3'd7, 16'hAAAA, 32'h5555_5555, 32'hFFFF_FFFF);
		send_cmd(lcbb_pkg::CMD_CLEAR, 16'd0, 32'd0, 32'h0);
		send_cmd(lcbb_pkg::CMD_LOOKUP, 16'd2, 32'd7, 32'h0);
	endtask

	task automatic test_limits();
		write_reg(2'(lcbb_pkg::REG_MAX_ENTRIES), 32'd0);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd4, 32'd4, 32'd4);
		write_reg(2'(lcbb_pkg::REG_MAX_ENTRIES), 32'd63);
		write_reg(2'(lcbb_pkg::REG_MAX_BYTES), 32'd0);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd4, 32'd4, 32'd4);
		write_reg(2'(lcbb_pkg::REG_MAX_BYTES), 32'd100);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd5, 32'd1, 32'd60);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd5, 32'd1, 32'd101);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd6, 32'd1, 32'd60);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd7, 32'd1, 32'd40);
		write_reg(2'(lcbb_pkg::REG_MAX_ENTRIES), 32'd1);
		send_cmd(lcbb_pkg::CMD_INSERT, 16'd8, 32'd1, 32'd10);
	endtask

	task automatic run_random(int count);
		logic [2:0]  cmd;
		logic [15:0] robot;
		logic [31:0] frame;
		logic [31:0] scan;
		for (int i = 0; i < count; i++) begin
			cmd = ($urandom_range(0, 9) < 5) ? lcbb_pkg::CMD_INSERT
				: 3'($urandom_range(1, 7));
			if (cmd == lcbb_pkg::CMD_CLEAR && $urandom_range(0, 3) != 0)
				cmd = lcbb_pkg::CMD_LOOKUP;
			if ($urandom_range(0, 15) == 0) begin
				robot = 16'($urandom);
				frame = $urandom;
			end else begin
				robot = 16'($urandom_range(1, 6));
				frame = $urandom_range(0, 5);
			end
			scan = ($urandom_range(0, 15) == 0) ? $urandom
				: (lim_bytes == 32'hFFFF_FFFF ? $urandom : $urandom_range(0, 300));
			send_cmd(cmd, robot, frame, scan);
		end
	endtask

	task automatic test_random();
		write_reg(2'(lcbb_pkg::REG_MAX_ENTRIES), 32'd4);
		write_reg(2'(lcbb_pkg::REG_MAX_BYTES), 32'd500);
		run_random(80);
		drain();
		write_reg(2'(lcbb_pkg::REG_MAX_ENTRIES), 32'd32);
		write_reg(2'(lcbb_pkg::REG_MAX_BYTES), 32'hFFFF_FFFF);
		run_random(80);
		write_reg(2'(lcbb_pkg::REG_MAX_ENTRIES), 32'd20);
		write_reg(2'(lcbb_pkg::REG_MAX_BYTES), 32'd1000);
		run_random(80);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		mismatches = 0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		lim_entries = lcbb_pkg::MAX_ENTRIES_RST;
		lim_bytes = lcbb_pkg::MAX_BYTES_RST;
		sum_bytes = '0;
		rejects = '0;
		evicts = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_random();
		drain();
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

### filelist.f
rtl/core/lcbb_pkg.sv
rtl/core/lcbb_ctrl.sv
rtl/core/lcbb_datapath.sv
rtl/core/lru_cache_byte_budget_unit.sv
rtl/core/lcbb_checker.sv
tb/sv/lru_cache_byte_budget_unit_tb.sv
